### hdl/sphere_grid_vertex_generator_macros.svh
// Assertion macros shared by the sphere grid vertex generator.
`ifndef SPHERE_GRID_VERTEX_GENERATOR_MACROS_SVH
`define SPHERE_GRID_VERTEX_GENERATOR_MACROS_SVH

// Checks expr in the same cycle as cond.
`define SGV_ASSERT_NOW(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// Checks expr in the cycle after cond.
`define SGV_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

### hdl/sgv_pkg.sv
// Types, constants and the arctangent table of the sphere grid vertex generator.
package sgv_pkg;

   localparam int MAX_GRID      = 1024;
   localparam int CORDIC_STAGES = 16;
   localparam int IDX_W         = $clog2(MAX_GRID);
   localparam int CNT_W         = IDX_W + 1;
   localparam int RAD_W         = 16;
   localparam int ANG_W         = 32;
   localparam int DIV_W         = IDX_W + ANG_W;
   localparam int DIV_STEPS     = DIV_W;
   localparam int XY_W          = 32;
   localparam int STAGE_W       = 5;
   localparam int TEX_W         = 17;
   localparam int POS_W         = 17;
   localparam int NRM_W         = 16;
   localparam int TEX_DLY       = CORDIC_STAGES + 4;
   localparam int PIPE_DEPTH    = DIV_STEPS + 1 + CORDIC_STAGES + 4;

   localparam logic signed [XY_W-1:0] CORDIC_GAIN = 32'sd652032874;
   localparam logic [TEX_W-1:0]       TEX_ONE     = 17'd65536;

   typedef enum logic [1:0] {
      CSR_ROW_COUNT     = 2'd0,
      CSR_COLUMN_COUNT  = 2'd1,
      CSR_SPHERE_RADIUS = 2'd2
   } csr_index_type;

   // One step of the long division: partial remainder, and the dividend bits
   // still to come with the quotient bits shifted in behind them.
   typedef struct packed {
      logic [IDX_W-1:0] rem;
      logic [DIV_W-1:0] work;
   } div_vec_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [XY_W-1:0] z;
      logic [1:0]             quad;
   } cordic_vec_type;

   // Arctangent of 2^-i in units of 2^-32 of a turn.
   function automatic logic [30:0] atan_turn(input logic [STAGE_W-1:0] i);
      logic [30:0] a;
      case (i)
         5'd0:  a = 31'd536870912;
         5'd1:  a = 31'd316933406;
         5'd2:  a = 31'd167458907;
         5'd3:  a = 31'd85004756;
         5'd4:  a = 31'd42667331;
         5'd5:  a = 31'd21354465;
         5'd6:  a = 31'd10679838;
         5'd7:  a = 31'd5340245;
         5'd8:  a = 31'd2670163;
         5'd9:  a = 31'd1335087;
         5'd10: a = 31'd667544;
         5'd11: a = 31'd333772;
         5'd12: a = 31'd166886;
         5'd13: a = 31'd83443;
         5'd14: a = 31'd41722;
         5'd15: a = 31'd20861;
         5'd16: a = 31'd10430;
         5'd17: a = 31'd5215;
         5'd18: a = 31'd2608;
         5'd19: a = 31'd1304;
         5'd20: a = 31'd652;
         5'd21: a = 31'd326;
         5'd22: a = 31'd163;
         5'd23: a = 31'd81;
         5'd24: a = 31'd41;
         5'd25: a = 31'd20;
         5'd26: a = 31'd10;
         5'd27: a = 31'd5;
         5'd28: a = 31'd3;
         5'd29: a = 31'd1;
         5'd30: a = 31'd1;
         default: a = 31'd0;
      endcase
      return a;
   endfunction

endpackage

### hdl/sgv_div_cell.sv
// One restoring-division cell: takes one dividend bit and yields one quotient bit.
module sgv_div_cell
   import sgv_pkg::*;
(
   input  logic             clock,
   input  logic             en,
   input  logic [IDX_W-1:0] divisor,
   input  div_vec_type      vec_i,
   output div_vec_type      vec_o
);

   div_vec_type    vec_ff;
   div_vec_type    vec_in;
   logic [IDX_W:0] trial;
   logic [IDX_W:0] diff;
   logic           fits;

   always_comb begin
      trial  = {vec_i.rem, vec_i.work[DIV_W-1]};
      diff   = trial - {1'b0, divisor};
      fits   = (trial >= {1'b0, divisor});
      vec_in.rem  = fits ? diff[IDX_W-1:0] : trial[IDX_W-1:0];
      vec_in.work = {vec_i.work[DIV_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff <= vec_in;
      end
   end

   assign vec_o = vec_ff;

endmodule

### hdl/sgv_cordic_cell.sv
// One rotation-mode CORDIC cell with a registered output.
module sgv_cordic_cell
   import sgv_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic [STAGE_W-1:0] stage,
   input  cordic_vec_type     vec_i,
   output cordic_vec_type     vec_o
);

   cordic_vec_type         vec_ff;
   cordic_vec_type         vec_in;
   logic signed [XY_W-1:0] dx;
   logic signed [XY_W-1:0] dy;
   logic signed [XY_W-1:0] at;

   always_comb begin
      dx = vec_i.x >>> stage;
      dy = vec_i.y >>> stage;
      at = signed'({1'b0, atan_turn(stage)});
      vec_in.quad = vec_i.quad;
      if (!vec_i.z[XY_W-1]) begin
         vec_in.x = vec_i.x - dy;
         vec_in.y = vec_i.y + dx;
         vec_in.z = vec_i.z - at;
      end else begin
         vec_in.x = vec_i.x + dy;
         vec_in.y = vec_i.y - dx;
         vec_in.z = vec_i.z + at;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff <= vec_in;
      end
   end

   assign vec_o = vec_ff;

endmodule

### hdl/sphere_grid_vertex_generator.sv
// Sphere grid vertex generator: grid point in, vertex position, normal and UV out.
//
// The req_ channel takes one grid point (row, column) per item; the rsp_ channel
// returns one vertex item per grid point, in order. Configuration goes through the
// csr_ channel (index 0 row count, 1 column count, 2 radius), always ready. The user
// must write it only while no item is in flight; the block does not enforce this.
// Throughput is one item per clock while the pipeline is not frozen. From the
// accepting edge to rsp_tvalid an item passes 42 division cells that form the row
// and column angles one quotient bit each, one rounding stage, 16 CORDIC cells per
// angle, four stages of products and rounding, and the output register.
// Reset clears every valid bit and loads row and column counts of 2 and a radius
// of 1.0; req_tready stays low while reset is high. When the receiver stalls, the
// output register holds its item while the pipeline keeps moving to close up empty
// slots; it freezes, and req_tready drops, only once an item waits right behind
// the output register.
module sphere_grid_vertex_generator
   import sgv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // grid_row[9:0], grid_column[19:10], zero pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // pos_x, pos_y, pos_z, normal_x, normal_y,
                                     // normal_z, tex_u, tex_v, zero pad
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_data
);

`include "sphere_grid_vertex_generator_macros.svh"

   logic [CNT_W-1:0] row_count_ff;
   logic [CNT_W-1:0] column_count_ff;
   logic [RAD_W-1:0] sphere_radius_ff;
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic             en;
   logic [IDX_W-1:0] d_row;
   logic [IDX_W-1:0] d_col;
   logic [IDX_W-1:0] h_row;
   logic [IDX_W-1:0] h_col;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff     <= CNT_W'(2);
         column_count_ff  <= CNT_W'(2);
         sphere_radius_ff <= RAD_W'(256);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ROW_COUNT:     row_count_ff     <= csr_data[CNT_W-1:0];
            CSR_COLUMN_COUNT:  column_count_ff  <= csr_data[CNT_W-1:0];
            CSR_SPHERE_RADIUS: sphere_radius_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Divisor is the effective count minus one, counts clamped to 2..MAX_GRID.
   always_comb begin
      if (row_count_ff < CNT_W'(2)) begin
         d_row = IDX_W'(1);
      end else if (row_count_ff > CNT_W'(MAX_GRID)) begin
         d_row = IDX_W'(MAX_GRID - 1);
      end else begin
         d_row = IDX_W'(row_count_ff - CNT_W'(1));
      end
      if (column_count_ff < CNT_W'(2)) begin
         d_col = IDX_W'(1);
      end else if (column_count_ff > CNT_W'(MAX_GRID)) begin
         d_col = IDX_W'(MAX_GRID - 1);
      end else begin
         d_col = IDX_W'(column_count_ff - CNT_W'(1));
      end
      h_row = d_row >> 1;
      h_col = d_col >> 1;
   end

   // The pipeline only stops when the output is held and an item waits behind it.
   assign en         = !(rsp_tvalid && !rsp_tready && vld_ff[PIPE_DEPTH-1]);
   assign req_tready = en && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_tvalid};
      end
   end

   // Division chains: row * 2^31 / d_row and column * 2^32 / d_col.
   div_vec_type div_row [0:DIV_STEPS];
   div_vec_type div_col [0:DIV_STEPS];

   always_comb begin
      div_row[0].rem  = '0;
      div_row[0].work = {1'b0, req_tdata[IDX_W-1:0], {(ANG_W-1){1'b0}}};
      div_col[0].rem  = '0;
      div_col[0].work = {req_tdata[2*IDX_W-1:IDX_W], {ANG_W{1'b0}}};
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      sgv_div_cell u_row (
         .clock   (clock),
         .en      (en),
         .divisor (d_row),
         .vec_i   (div_row[k]),
         .vec_o   (div_row[k+1])
      );
      sgv_div_cell u_col (
         .clock   (clock),
         .en      (en),
         .divisor (d_col),
         .vec_i   (div_col[k]),
         .vec_o   (div_col[k+1])
      );
   end

   // Rounding of the angles, and the remainder products for the texture coordinates.
   div_vec_type         qr;
   div_vec_type         qc;
   logic [ANG_W-1:0]    theta_ff;
   logic [ANG_W-1:0]    phi_ff;
   logic [25:0]         prod_u_ff;
   logic [24:0]         prod_v_ff;
   logic [25:0]         q16_u_ff;
   logic [26:0]         q16_v_ff;
   logic                inc_row;
   logic                inc_col;

   always_comb begin
      qr      = div_row[DIV_STEPS];
      qc      = div_col[DIV_STEPS];
      inc_row = ({1'b0, qr.rem} + {1'b0, h_row}) >= {1'b0, d_row};
      inc_col = ({1'b0, qc.rem} + {1'b0, h_col}) >= {1'b0, d_col};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         theta_ff  <= qr.work[ANG_W-1:0] + ANG_W'(inc_row);
         phi_ff    <= qc.work[ANG_W-1:0] + ANG_W'(inc_col);
         prod_u_ff <= 26'(qc.work[15:0]) * 26'(d_col) + 26'(qc.rem);
         prod_v_ff <= 25'(qr.work[14:0]) * 25'(d_row) + 25'(qr.rem);
         q16_u_ff  <= qc.work[DIV_W-1:16];
         q16_v_ff  <= qr.work[DIV_W-1:15];
      end
   end

   // Texture coordinates, then a delay line alongside the CORDIC and product stages.
   logic [TEX_W-1:0] tex_u_line [0:TEX_DLY-1];
   logic [TEX_W-1:0] tex_v_line [0:TEX_DLY-1];
   logic [TEX_W-1:0] tex_u_in;
   logic [TEX_W-1:0] tex_v_in;
   logic [IDX_W-1:0] r16_u;
   logic [IDX_W-1:0] r16_v;

   always_comb begin
      r16_u = prod_u_ff[25:16];
      r16_v = prod_v_ff[24:15];
      if (q16_u_ff > 26'd65535) begin
         tex_u_in = TEX_ONE;
      end else begin
         tex_u_in = q16_u_ff[TEX_W-1:0]
                  + TEX_W'(({1'b0, r16_u} + {1'b0, h_col}) >= {1'b0, d_col});
      end
      if (q16_v_ff > 27'd65535) begin
         tex_v_in = TEX_ONE;
      end else begin
         tex_v_in = q16_v_ff[TEX_W-1:0]
                  + TEX_W'(({1'b0, r16_v} + {1'b0, h_row}) >= {1'b0, d_row});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tex_u_line[0] <= tex_u_in;
         tex_v_line[0] <= tex_v_in;
         for (int m = 1; m < TEX_DLY; m++) begin
            tex_u_line[m] <= tex_u_line[m-1];
            tex_v_line[m] <= tex_v_line[m-1];
         end
      end
   end

   // CORDIC chains for the polar angle and the azimuth.
   cordic_vec_type cor_t [0:CORDIC_STAGES];
   cordic_vec_type cor_p [0:CORDIC_STAGES];

   always_comb begin
      cor_t[0].x    = CORDIC_GAIN;
      cor_t[0].y    = '0;
      cor_t[0].z    = signed'({2'b00, theta_ff[ANG_W-3:0]});
      cor_t[0].quad = theta_ff[ANG_W-1:ANG_W-2];
      cor_p[0].x    = CORDIC_GAIN;
      cor_p[0].y    = '0;
      cor_p[0].z    = signed'({2'b00, phi_ff[ANG_W-3:0]});
      cor_p[0].quad = phi_ff[ANG_W-1:ANG_W-2];
   end

   for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_cordic
      sgv_cordic_cell u_theta (
         .clock (clock),
         .en    (en),
         .stage (STAGE_W'(j)),
         .vec_i (cor_t[j]),
         .vec_o (cor_t[j+1])
      );
      sgv_cordic_cell u_phi (
         .clock (clock),
         .en    (en),
         .stage (STAGE_W'(j)),
         .vec_i (cor_p[j]),
         .vec_o (cor_p[j+1])
      );
   end

   // Quadrant correction.
   logic signed [XY_W-1:0] ct_in, st_in, cp_in, sp_in;
   logic signed [XY_W-1:0] ct_ff, st_ff, cp_ff, sp_ff;
   cordic_vec_type         ft;
   cordic_vec_type         fp;

   always_comb begin
      ft = cor_t[CORDIC_STAGES];
      fp = cor_p[CORDIC_STAGES];
      case (ft.quad)
         2'd0:    begin ct_in = ft.x;  st_in = ft.y;  end
         2'd1:    begin ct_in = -ft.y; st_in = ft.x;  end
         2'd2:    begin ct_in = -ft.x; st_in = -ft.y; end
         default: begin ct_in = ft.y;  st_in = -ft.x; end
      endcase
      case (fp.quad)
         2'd0:    begin cp_in = fp.x;  sp_in = fp.y;  end
         2'd1:    begin cp_in = -fp.y; sp_in = fp.x;  end
         2'd2:    begin cp_in = -fp.x; sp_in = -fp.y; end
         default: begin cp_in = fp.y;  sp_in = -fp.x; end
      endcase
   end

   logic signed [2*XY_W-1:0] sxs_ff;
   logic signed [2*XY_W-1:0] sxc_ff;
   logic signed [XY_W-1:0]   ct2_ff;
   logic signed [XY_W:0]     dir_ff [0:2];
   logic signed [2*XY_W-1:0] sxs_rnd;
   logic signed [2*XY_W-1:0] sxc_rnd;
   logic signed [XY_W+RAD_W+1:0] pprod_ff [0:2];
   logic signed [NRM_W-1:0]  nrm_ff [0:2];
   logic signed [NRM_W-1:0]  nrm_in [0:2];
   logic signed [XY_W+1:0]   nsum [0:2];
   logic signed [17:0]       nraw [0:2];
   logic signed [RAD_W:0]    rad_s;

   always_comb begin
      sxs_rnd = sxs_ff + (64'sd1 <<< 29);
      sxc_rnd = sxc_ff + (64'sd1 <<< 29);
      rad_s   = signed'({1'b0, sphere_radius_ff});
      for (int a = 0; a < 3; a++) begin
         nsum[a] = {dir_ff[a][XY_W], dir_ff[a]} + 34'sd32768;
         nraw[a] = nsum[a][XY_W+1:16];
         if (nraw[a] > 18'sd16384) begin
            nrm_in[a] = 16'sd16384;
         end else if (nraw[a] < -18'sd16384) begin
            nrm_in[a] = -16'sd16384;
         end else begin
            nrm_in[a] = nraw[a][NRM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ct_ff  <= ct_in;
         st_ff  <= st_in;
         cp_ff  <= cp_in;
         sp_ff  <= sp_in;
         sxs_ff <= st_ff * sp_ff;
         sxc_ff <= st_ff * cp_ff;
         ct2_ff <= ct_ff;
         dir_ff[0] <= sxs_rnd[2*XY_W-2:30];
         dir_ff[1] <= {ct2_ff[XY_W-1], ct2_ff};
         dir_ff[2] <= sxc_rnd[2*XY_W-2:30];
         for (int a = 0; a < 3; a++) begin
            pprod_ff[a] <= rad_s * dir_ff[a];
            nrm_ff[a]   <= nrm_in[a];
         end
      end
   end

   // Position rounding and saturation feed the output register.
   logic signed [XY_W+RAD_W+1:0] psum [0:2];
   logic signed [19:0]           praw [0:2];
   logic signed [POS_W-1:0]      pos_in [0:2];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         psum[a] = pprod_ff[a] + (50'sd1 <<< 29);
         praw[a] = psum[a][XY_W+RAD_W+1:30];
         if (praw[a] > 20'sd65535) begin
            pos_in[a] = 17'sd65535;
         end else if (praw[a] < -20'sd65535) begin
            pos_in[a] = -17'sd65535;
         end else begin
            pos_in[a] = praw[a][POS_W-1:0];
         end
      end
   end

   logic                rsp_tvalid_ff;
   logic [135:0]        rsp_tdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (!rsp_tvalid_ff || rsp_tready) begin
         rsp_tvalid_ff <= vld_ff[PIPE_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_tvalid_ff || rsp_tready) begin
         rsp_tdata_ff <= {3'b000,
                          tex_v_line[TEX_DLY-1], tex_u_line[TEX_DLY-1],
                          nrm_ff[2], nrm_ff[1], nrm_ff[0],
                          pos_in[2], pos_in[1], pos_in[0]};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   `SGV_ASSERT_NOW(a_stall_blocks_input, rsp_tvalid && !rsp_tready && vld_ff[PIPE_DEPTH-1], !req_tready, "input accepted while the pipeline is frozen")
   `SGV_ASSERT_NEXT(a_accept_enters_pipe, req_tvalid && req_tready, vld_ff[0], "accepted item did not enter the division chain")
   `SGV_ASSERT_NOW(a_tex_range, rsp_tvalid, rsp_tdata[115:99] <= TEX_ONE && rsp_tdata[132:116] <= TEX_ONE, "texture coordinate above one")
   `SGV_ASSERT_NOW(a_normal_range, rsp_tvalid, $signed(rsp_tdata[82:67]) <= 16'sd16384 && $signed(rsp_tdata[82:67]) >= -16'sd16384, "normal y outside the unit range")

endmodule

### tb/tb_top.sv
// Testbench for the sphere grid vertex generator: random grid points checked against a vertex predictor.
`timescale 1ns / 100ps

class vertex_scoreboard;
   logic [10:0] row_count;
   logic [10:0] column_count;
   logic [15:0] sphere_radius;
   logic [135:0] pending_vertices[$];
   int mismatch_count;

   function new();
      row_count = 11'd2;
      column_count = 11'd2;
      sphere_radius = 16'd256;
      mismatch_count = 0;
   endfunction

   function void write_register(sgv_pkg::csr_index_type idx, logic [15:0] value);
      case (idx)
         sgv_pkg::CSR_ROW_COUNT:     row_count = value[10:0];
         sgv_pkg::CSR_COLUMN_COUNT:  column_count = value[10:0];
         sgv_pkg::CSR_SPHERE_RADIUS: sphere_radius = value;
         default: ;
      endcase
   endfunction

   static function longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   static function longint round_shr(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   static function longint clamp(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   static function longint grid_count(logic [10:0] c);
      if (c < 2) return 2;
      if (c > sgv_pkg::MAX_GRID) return sgv_pkg::MAX_GRID;
      return c;
   endfunction

   static function void rotate(logic [31:0] ang, output longint c, output longint s);
      longint x, y, z, dx, dy;
      logic [30:0] a;
      x = 652032874;
      y = 0;
      z = longint'(ang[29:0]);
      for (int i = 0; i < sgv_pkg::CORDIC_STAGES; i++) begin
         a = sgv_pkg::atan_turn(i[4:0]);
         dx = floor_shr(y, i);
         dy = floor_shr(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(a);
         end else begin
            x += dx; y -= dy; z += longint'(a);
         end
      end
      case (ang[31:30])
         2'd0: begin c = x; s = y; end
         2'd1: begin c = -y; s = x; end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   static function logic [16:0] texture(longint idx, longint cnt);
      longint d, v;
      d = cnt - 1;
      v = (idx * 65536 + d / 2) / d;
      return (v > 65536) ? 17'd65536 : v[16:0];
   endfunction

   function void note_grid_point(logic [9:0] row, logic [9:0] col);
      longint rows, cols, ct, st, cp, sp, p, n;
      longint dir[3];
      logic [31:0] theta, phi;
      logic [135:0] v;
      rows = grid_count(row_count);
      cols = grid_count(column_count);
      theta = 32'((longint'(row) * (longint'(1) <<< 31) + (rows - 1) / 2) / (rows - 1));
      phi = 32'((longint'(col) * (longint'(1) <<< 32) + (cols - 1) / 2) / (cols - 1));
      rotate(theta, ct, st);
      rotate(phi, cp, sp);
      dir[0] = round_shr(st * sp, 30);
      dir[1] = ct;
      dir[2] = round_shr(st * cp, 30);
      v = '0;
      for (int k = 0; k < 3; k++) begin
         p = clamp(round_shr(longint'(sphere_radius) * dir[k], 30), 65535);
         n = clamp(round_shr(dir[k], 16), 16384);
         v[k*17 +: 17] = p[16:0];
         v[51 + k*16 +: 16] = n[15:0];
      end
      v[99 +: 17] = texture(col, cols);
      v[116 +: 17] = texture(row, rows);
      pending_vertices.push_back(v);
   endfunction

   function void check_vertex(logic [135:0] got);
      logic [135:0] want;
      if (pending_vertices.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10) $display("unexpected vertex %h", got);
         return;
      end
      want = pending_vertices.pop_front();
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10) $display("vertex mismatch: expected %h actual %h", want, got);
      end
   endfunction
endclass

module tb_top;
   import sgv_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [23:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [135:0] rsp_tdata;
   logic csr_valid = 0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   vertex_scoreboard vertices = new();
   int hold_cycles = 0;
   bit hold_request = 0;
   bit hold_started = 0;

   always #2 clock = ~clock;

   sphere_grid_vertex_generator dut (.*);

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) vertices.check_vertex(rsp_tdata);
   end

   // Receiver: random stalls, a few longer holds, and one long hold on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 0;
      end else if (hold_request && !hold_started) begin
         hold_started <= 1;
         hold_cycles <= 300;
         rsp_tready <= 0;
      end else if ($urandom_range(0, 49) == 0) begin
         hold_cycles <= int'($urandom_range(5, 40));
         rsp_tready <= 0;
      end else if ($urandom_range(0, 9) < 7) begin
         rsp_tready <= 1;
      end else begin
         rsp_tready <= 0;
      end
   end

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) n = 0;
      if (n > 0) begin
         req_tvalid <= 0;
         repeat (n) @(negedge clock);
      end
   endtask

   // Leaves req_tvalid high so that the next item can follow without a gap.
   task automatic send_point(logic [9:0] row, logic [9:0] col);
      req_tvalid <= 1;
      req_tdata <= {4'd0, col, row};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      vertices.note_grid_point(row, col);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (vertices.pending_vertices.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [15:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      vertices.write_register(idx, value);
      @(negedge clock);
   endtask

   task automatic random_point(int rows, int cols);
      logic [9:0] r, c;
      if ($urandom_range(0, 9) == 0) begin
         r = 10'($urandom); c = 10'($urandom);
      end else begin
         r = 10'($urandom_range(0, rows - 1)); c = 10'($urandom_range(0, cols - 1));
      end
      send_point(r, c);
   endtask

   task automatic run_phase(logic [15:0] rows, logic [15:0] cols, logic [15:0] radius, int n);
      drain();
      write_csr(CSR_ROW_COUNT, rows);
      write_csr(CSR_COLUMN_COUNT, cols);
      write_csr(CSR_SPHERE_RADIUS, radius);
      csr_valid <= 0;
      for (int i = 0; i < n; i++) begin
         random_point((rows < 2) ? 2 : (rows > 1024 ? 1024 : rows),
                      (cols < 2) ? 2 : (cols > 1024 ? 1024 : cols));
         if (i > n / 2) idle_gap();
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // Directed corners at reset settings: poles and wrap past count.
      send_point(10'd0, 10'd0);
      send_point(10'd1, 10'd1);
      send_point(10'd1023, 10'd1023);
      send_point(10'd2, 10'd3);
      drain();
      write_csr(CSR_ROW_COUNT, 16'd9);
      write_csr(CSR_COLUMN_COUNT, 16'd17);
      write_csr(CSR_SPHERE_RADIUS, 16'd0);
      csr_valid <= 0;
      for (int i = 0; i < 9; i++) send_point(i[9:0], 10'(2 * i));
      send_point(10'd0, 10'd16);
      run_phase(16'd1, 16'd0, 16'd65535, 60);
      run_phase(16'h7FF, 16'd1025, 16'd1, 150);
      run_phase(16'd1024, 16'd1024, 16'hAAAA, 150);
      run_phase(16'd3, 16'd5, 16'h5555, 150);
      // Long receiver hold while the sender keeps offering points.
      hold_request = 1;
      for (int i = 0; i < 120; i++) random_point(33, 65);
      run_phase(16'd33, 16'd65, 16'd700, 150);
      run_phase(16'd2, 16'd1000, 16'd256, 120);
      drain();
      if (vertices.mismatch_count == 0 && vertices.pending_vertices.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
